// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL; the decode unit includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hw/rtl/mahd_pkg.sv -----
`default_nettype none

package mahd_pkg;

  // Header field codes.
  localparam logic [31:0] SYNC_MASK = 32'hFFE0_0000;
  localparam logic [1:0]  VER_25    = 2'd0;
  localparam logic [1:0]  VER_RSVD  = 2'd1;
  localparam logic [1:0]  VER_2     = 2'd2;
  localparam logic [1:0]  VER_1     = 2'd3;
  localparam logic [1:0]  LAY_RSVD  = 2'd0;
  localparam logic [1:0]  LAY_3     = 2'd1;
  localparam logic [1:0]  LAY_2     = 2'd2;
  localparam logic [1:0]  LAY_1     = 2'd3;
  localparam logic [1:0]  MODE_MONO = 2'd3;
  localparam logic [1:0]  SRI_RSVD  = 2'd3;
  localparam logic [3:0]  BRI_FREE  = 4'd0;
  localparam logic [3:0]  BRI_BAD   = 4'd15;

  // Samples per frame.
  localparam logic [10:0] SPF_L1     = 11'd384;
  localparam logic [10:0] SPF_L23_V1 = 11'd1152;
  localparam logic [10:0] SPF_L23_V2 = 11'd576;

  // Channel counts.
  localparam logic [1:0] CHAN_MONO   = 2'd1;
  localparam logic [1:0] CHAN_STEREO = 2'd2;

  // Base sampling rates by sample-rate index.
  localparam logic [15:0] RATE_44K1 = 16'd44100;
  localparam logic [15:0] RATE_48K  = 16'd48000;
  localparam logic [15:0] RATE_32K  = 16'd32000;

  // Frame length is kbps * NUM / DEN with the fraction reduced per case.
  localparam int X_W         = 17;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [7:0] DEN_1   = 8'd1;
  localparam logic [7:0] DEN_2   = 8'd2;
  localparam logic [7:0] DEN_4   = 8'd4;
  localparam logic [7:0] DEN_8   = 8'd8;
  localparam logic [7:0] DEN_49  = 8'd49;
  localparam logic [7:0] DEN_147 = 8'd147;
  localparam logic [RECIP_W-1:0] RECIP_1   = RECIP_W'(64'd1 << RECIP_SHIFT);
  localparam logic [RECIP_W-1:0] RECIP_2   = RECIP_W'((64'd1 << RECIP_SHIFT) / 2);
  localparam logic [RECIP_W-1:0] RECIP_4   = RECIP_W'((64'd1 << RECIP_SHIFT) / 4);
  localparam logic [RECIP_W-1:0] RECIP_8   = RECIP_W'((64'd1 << RECIP_SHIFT) / 8);
  localparam logic [RECIP_W-1:0] RECIP_49  = RECIP_W'((64'd1 << RECIP_SHIFT) / 49);
  localparam logic [RECIP_W-1:0] RECIP_147 = RECIP_W'((64'd1 << RECIP_SHIFT) / 147);

  // Bitrate tables indexed by the raw bitrate index; 0 and 15 are unused.
  localparam logic [8:0] KBPS_V1_L1 [16] = '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160,
    9'd192, 9'd224, 9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
  localparam logic [8:0] KBPS_V2_L1 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
    9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
  localparam logic [8:0] KBPS_V1_L2 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
    9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
  localparam logic [8:0] KBPS_V1_L3 [16] = '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64,
    9'd80, 9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
  localparam logic [8:0] KBPS_V2_L23 [16] = '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40,
    9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

  // Decoded fields that travel beside the frame length arithmetic.
  typedef struct packed {
    logic        ok;
    logic        lay1;
    logic        pad;
    logic [15:0] rate;
    logic [1:0]  chan;
    logic [8:0]  kbps;
    logic [10:0] spf;
  } info_t;

  typedef struct packed {
    logic [8:0] num;
    logic [7:0] den;
  } ratio_t;

  // Bitrate in kbit/s for a version, layer and bitrate index.
  function automatic logic [8:0] kbps_lookup(input logic [1:0] ver, input logic [1:0] lay,
                                             input logic [3:0] bri);
    logic [8:0] kbps;
    if (lay == LAY_1) begin
      kbps = (ver == VER_1) ? KBPS_V1_L1[bri] : KBPS_V2_L1[bri];
    end else if (ver == VER_1) begin
      kbps = (lay == LAY_2) ? KBPS_V1_L2[bri] : KBPS_V1_L3[bri];
    end else begin
      kbps = KBPS_V2_L23[bri];
    end
    return kbps;
  endfunction

  // Sampling rate: base rate, halved for V2 and quartered for V2.5.
  function automatic logic [15:0] rate_lookup(input logic [1:0] ver, input logic [1:0] sri);
    logic [15:0] base;
    logic [15:0] rate;
    case (sri)
      2'd0:    base = RATE_44K1;
      2'd1:    base = RATE_48K;
      2'd2:    base = RATE_32K;
      default: base = '0;
    endcase
    case (ver)
      VER_2:   rate = base >> 1;
      VER_25:  rate = base >> 2;
      default: rate = base;
    endcase
    return rate;
  endfunction

  // Reduced fraction that turns kbps into bytes, or layer I slots, before padding.
  function automatic ratio_t ratio_lookup(input logic lay1, input logic [1:0] ver,
                                          input logic [1:0] sri);
    ratio_t r;
    r = '{num: 9'd0, den: DEN_1};
    if (lay1) begin
      unique case (ver)
        VER_1: begin
          case (sri)
            2'd0:    r = '{num: 9'd40, den: DEN_147};
            2'd1:    r = '{num: 9'd1, den: DEN_4};
            default: r = '{num: 9'd3, den: DEN_8};
          endcase
        end
        VER_2: begin
          case (sri)
            2'd0:    r = '{num: 9'd80, den: DEN_147};
            2'd1:    r = '{num: 9'd1, den: DEN_2};
            default: r = '{num: 9'd3, den: DEN_4};
          endcase
        end
        default: begin
          case (sri)
            2'd0:    r = '{num: 9'd160, den: DEN_147};
            2'd1:    r = '{num: 9'd1, den: DEN_1};
            default: r = '{num: 9'd3, den: DEN_2};
          endcase
        end
      endcase
    end else if (ver == VER_25) begin
      case (sri)
        2'd0:    r = '{num: 9'd320, den: DEN_49};
        2'd1:    r = '{num: 9'd6, den: DEN_1};
        default: r = '{num: 9'd9, den: DEN_1};
      endcase
    end else begin
      case (sri)
        2'd0:    r = '{num: 9'd160, den: DEN_49};
        2'd1:    r = '{num: 9'd3, den: DEN_1};
        default: r = '{num: 9'd9, den: DEN_2};
      endcase
    end
    return r;
  endfunction

  // Scaled reciprocal of a denominator; it never overestimates the quotient.
  function automatic logic [RECIP_W-1:0] recip_lookup(input logic [7:0] den);
    logic [RECIP_W-1:0] m;
    unique case (den)
      DEN_1:   m = RECIP_1;
      DEN_2:   m = RECIP_2;
      DEN_4:   m = RECIP_4;
      DEN_8:   m = RECIP_8;
      DEN_49:  m = RECIP_49;
      DEN_147: m = RECIP_147;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mpeg_audio_header_decode_unit.sv -----
// An accepted header moves through the stage 1, 2 and 3 registers into the output register.
// Throughput: one header per cycle; the four-stage pipeline moves as a whole and holds
// only while a finished result is stalled at the output.
// Reset: synchronous active-high rst clears all stage valid bits; no clearing pass.
// Stages: decode and table lookups, bitrate multiply, reciprocal multiply, correction.
`default_nettype none
`include "assert_macros.svh"

module mpeg_audio_header_decode_unit import mahd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] header_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             header_ok,
  output logic [10:0]      frame_bytes,
  output logic [15:0]      sample_rate_hz,
  output logic [1:0]       channel_count,
  output logic [8:0]       bitrate_kbps,
  output logic [10:0]      samples_per_frame
);

  // The whole pipeline advances unless a finished result is held at the output.
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Stage 1: field checks and table lookups.
  logic [1:0] ver;
  logic [1:0] lay;
  logic [3:0] bri;
  logic [1:0] sri;
  logic       hdr_ok;
  info_t      info1_next;
  ratio_t     ratio1_next;

  assign ver = header_word[20:19];
  assign lay = header_word[18:17];
  assign bri = header_word[15:12];
  assign sri = header_word[11:10];

  always_comb begin
    hdr_ok = ((header_word & SYNC_MASK) == SYNC_MASK) && (ver != VER_RSVD)
             && (lay != LAY_RSVD) && (bri != BRI_FREE) && (bri != BRI_BAD)
             && (sri != SRI_RSVD);
    info1_next.ok   = hdr_ok;
    info1_next.lay1 = hdr_ok && (lay == LAY_1);
    info1_next.pad  = hdr_ok && header_word[9];
    info1_next.rate = hdr_ok ? rate_lookup(ver, sri) : '0;
    info1_next.chan = !hdr_ok ? 2'd0
                    : (header_word[7:6] == MODE_MONO) ? CHAN_MONO : CHAN_STEREO;
    info1_next.kbps = hdr_ok ? kbps_lookup(ver, lay, bri) : '0;
    if (!hdr_ok) begin
      info1_next.spf = SPF_L23_V1;
    end else if (lay == LAY_1) begin
      info1_next.spf = SPF_L1;
    end else if (ver == VER_1) begin
      info1_next.spf = SPF_L23_V1;
    end else begin
      info1_next.spf = SPF_L23_V2;
    end
    ratio1_next = hdr_ok ? ratio_lookup(lay == LAY_1, ver, sri)
                         : ratio_t'{num: 9'd0, den: DEN_1};
  end

  logic   v1;
  info_t  info1;
  ratio_t ratio1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      info1  <= info1_next;
      ratio1 <= ratio1_next;
    end
  end

  // Stage 2: scale the bitrate by the numerator of the fraction.
  logic [17:0] x_full;
  assign x_full = {9'd0, info1.kbps} * {9'd0, ratio1.num};

  logic               v2;
  info_t              info2;
  logic [X_W-1:0]     x2;
  logic [7:0]         den2;
  logic [RECIP_W-1:0] recip2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      info2  <= info1;
      x2     <= x_full[X_W-1:0];
      den2   <= ratio1.den;
      recip2 <= recip_lookup(ratio1.den);
    end
  end

  // Stage 3: quotient estimate by reciprocal multiply; it is exact or one low.
  logic [X_W+RECIP_W-1:0] qprod;
  assign qprod = {{RECIP_W{1'b0}}, x2} * {{X_W{1'b0}}, recip2};

  logic           v3;
  info_t          info3;
  logic [X_W-1:0] x3;
  logic [7:0]     den3;
  logic [X_W-1:0] q3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      info3 <= info2;
      x3    <= x2;
      den3  <= den2;
      q3    <= qprod[RECIP_SHIFT +: X_W];
    end
  end

  // Stage 4: correct the quotient, add padding and scale layer I slots to bytes.
  logic [X_W+7:0] qden;
  logic [X_W:0]   rem;
  logic [X_W-1:0] q_fix;
  logic [X_W-1:0] slots;
  logic [10:0]    bytes_next;

  always_comb begin
    qden  = {8'd0, q3} * {{X_W{1'b0}}, den3};
    rem   = {1'b0, x3} - qden[X_W:0];
    q_fix = q3 + X_W'(rem >= {{(X_W-7){1'b0}}, den3});
    slots = q_fix + X_W'(info3.pad);
    bytes_next = info3.lay1 ? 11'({slots, 2'b00}) : 11'(slots);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      header_ok         <= info3.ok;
      frame_bytes       <= bytes_next;
      sample_rate_hz    <= info3.rate;
      channel_count     <= info3.chan;
      bitrate_kbps      <= info3.kbps;
      samples_per_frame <= info3.spf;
    end
  end

  // A rejected header leaves every decoded field at its invalid value.
  `ASSERT_SAME(a_invalid_zero, clk, rst, out_valid && !header_ok,
    frame_bytes == 11'd0 && sample_rate_hz == 16'd0 && channel_count == 2'd0 &&
    bitrate_kbps == 9'd0 && samples_per_frame == SPF_L23_V1)
  // A decoded header always has a channel count and a legal frame size.
  `ASSERT_SAME(a_ok_fields, clk, rst, out_valid && header_ok,
    channel_count != 2'd0 && frame_bytes != 11'd0 &&
    (samples_per_frame == SPF_L1 || samples_per_frame == SPF_L23_V1 ||
     samples_per_frame == SPF_L23_V2))
  // An item in the last stage is never dropped while the output is held.
  `ASSERT_NEXT(a_hold_keeps_item, clk, rst, v3 && !adv, v3 && out_valid)
  // An input transfer always lands in the first stage.
  `ASSERT_NEXT(a_accept_enters, clk, rst, in_valid && !in_stall, v1)
  // The corrected quotient never needs a second correction step.
  `ASSERT_SAME(a_rem_bound, clk, rst, v3,
    rem < {{(X_W-8){1'b0}}, den3, 1'b0})

endmodule

`default_nettype wire
